// ===== design/thc_pkg.sv =====
// ============================================================================
// thc_pkg: shared types and constants for the twelve-hour clock
// Item layouts, event codes, setting-field codes, time limits and the
// decimal digit split used by the display path.
// ============================================================================
`default_nettype none

package thc_pkg;

  // Event codes carried in the opcode field of an input item.
  localparam logic [1:0] OP_SECOND = 2'd0;
  localparam logic [1:0] OP_SCAN   = 2'd1;
  localparam logic [1:0] OP_MODE   = 2'd2;

  // Setting-field codes.
  localparam logic [1:0] FIELD_RUN     = 2'd0;
  localparam logic [1:0] FIELD_HOURS   = 2'd1;
  localparam logic [1:0] FIELD_MINUTES = 2'd2;
  localparam logic [1:0] FIELD_SECONDS = 2'd3;

  // Time limits.
  localparam logic [3:0] HOUR_MIN = 4'd1;
  localparam logic [3:0] HOUR_MAX = 4'd12;
  localparam logic [5:0] MS_MAX   = 6'd59;

  // Scan sequence: positions 0 to 6, and the digit shown at positions 6 and 0.
  localparam logic [2:0] SCAN_LAST  = 3'd6;
  localparam logic [2:0] DIGIT_LAST = 3'd5;

  // Repeat counter saturation value and threshold reset value.
  localparam logic [7:0] REPEAT_MAX       = 8'd255;
  localparam logic [7:0] THRESHOLD_RESET  = 8'd6;

  // Configuration register map.
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;

  typedef struct packed {
    logic [1:0] opcode;
    logic       inc_held;
    logic       dec_held;
  } in_item_t;

  typedef struct packed {
    logic [2:0] digit_index;
    logic [3:0] digit_value;
    logic       digit_enable;
    logic [1:0] setting_field;
    logic [3:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
  } out_item_t;

  // Tens digit of a value below 64, by comparison against the decades.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  // Units digit: the value less ten times its tens digit.
  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [6:0] tens_x10;
    logic [6:0] diff;
    tens_x10 = 7'(tens_of(v)) * 7'd10;
    diff     = 7'(v) - tens_x10;
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/twelve_hour_clock_with_setting.sv =====
// ============================================================================
// twelve_hour_clock_with_setting: 12-hour clock with field setting
// Keeps hours, minutes and seconds, steps through setting modes, repeats
// held-button adjustments and reports one multiplexed display digit per item.
// ============================================================================
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | sink      | in_valid_i/in_stall_o | in_item_i  (opcode, buttons)
//  out      | source    | out_valid_o/out_stall_i | out_item_o (digit and time)
//  cfg      | APB slave | psel/penable/pready   | repeat_threshold at address 0
//
//  One item is accepted per cycle unless the input stalls. Its whole update
//  is one combinational pass from the state registers into the state and the
//  result register, so the result follows acceptance in the next cycle. The
//  input stalls only while a result is held in the output register and the
//  output side stalls; a taken result frees the register in the same cycle.
//  Reset returns the time to 1:00:00, run mode, and the threshold to six.
//
`default_nettype none

module twelve_hour_clock_with_setting (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Event input.
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire thc_pkg::in_item_t         in_item_i,
  // Display and time output.
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output thc_pkg::out_item_t             out_item_o,
  // Configuration port.
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [thc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import thc_pkg::*;

  // Clock state.
  logic [3:0] hour_q,   hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  logic [2:0] scan_q,   scan_d;
  logic [7:0] repeat_q, repeat_d;
  logic [1:0] field_q,  field_d;
  logic [7:0] threshold_q;

  // Result register.
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic in_accept;
  logic cfg_write;

  // The input moves whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Configuration port. The threshold is the only register.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_THRESHOLD) begin
      prdata = {24'd0, threshold_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_write && paddr == ADDR_THRESHOLD) begin
      threshold_q <= pwdata[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Next state: the event first, then the held-button adjustment, which sees
  // the field and repeat count that the event left behind.
  // --------------------------------------------------------------------------
  logic [3:0] hour_e;
  logic [5:0] minute_e, second_e;
  logic [7:0] repeat_e;
  logic [1:0] field_e;
  logic       step_en, step_up;
  logic [2:0] digit;
  logic [5:0] pair;

  always_comb begin
    hour_e   = hour_q;
    minute_e = minute_q;
    second_e = second_q;
    scan_d   = scan_q;
    repeat_e = repeat_q;
    field_e  = field_q;

    unique case (in_item_i.opcode)
      OP_SECOND: begin
        // Time runs only in run mode; seconds carry into minutes and hours.
        if (field_q == FIELD_RUN) begin
          if (second_q >= MS_MAX) begin
            second_e = '0;
            if (minute_q >= MS_MAX) begin
              minute_e = '0;
              hour_e   = (hour_q >= HOUR_MAX) ? HOUR_MIN : hour_q + 4'd1;
            end else begin
              minute_e = minute_q + 6'd1;
            end
          end else begin
            second_e = second_q + 6'd1;
          end
        end
      end
      OP_SCAN: begin
        // One scan round ends after position six and counts toward a repeat.
        if (scan_q >= SCAN_LAST) begin
          scan_d = '0;
          if (repeat_q != REPEAT_MAX) begin
            repeat_e = repeat_q + 8'd1;
          end
        end else begin
          scan_d = scan_q + 3'd1;
        end
      end
      OP_MODE: begin
        field_e = field_q + 2'd1;
      end
      default: begin
        // The unused code leaves the event state alone.
      end
    endcase

    hour_d   = hour_e;
    minute_d = minute_e;
    second_d = second_e;
    field_d  = field_e;
    repeat_d = repeat_e;

    // Increment wins over decrement when both buttons are held.
    step_en = (field_e != FIELD_RUN) && (repeat_e >= threshold_q) &&
              (in_item_i.inc_held || in_item_i.dec_held);
    step_up = in_item_i.inc_held;

    if (field_e == FIELD_RUN) begin
      repeat_d = '0;
    end else if (step_en) begin
      repeat_d = '0;
      unique case (field_e)
        FIELD_HOURS: begin
          if (step_up) begin
            hour_d = (hour_e >= HOUR_MAX) ? HOUR_MIN : hour_e + 4'd1;
          end else begin
            hour_d = (hour_e <= HOUR_MIN) ? HOUR_MAX : hour_e - 4'd1;
          end
        end
        FIELD_MINUTES: begin
          if (step_up) begin
            minute_d = (minute_e >= MS_MAX) ? 6'd0 : minute_e + 6'd1;
          end else begin
            minute_d = (minute_e == 6'd0) ? MS_MAX : minute_e - 6'd1;
          end
        end
        FIELD_SECONDS: begin
          if (step_up) begin
            second_d = (second_e >= MS_MAX) ? 6'd0 : second_e + 6'd1;
          end else begin
            second_d = (second_e == 6'd0) ? MS_MAX : second_e - 6'd1;
          end
        end
        default: begin
          // Run mode is handled above.
        end
      endcase
    end

    // Display: positions one to five show digits zero to four, and positions
    // six and zero both show the last seconds digit.
    digit = (scan_d >= 3'd1 && scan_d <= 3'd5) ? scan_d - 3'd1 : DIGIT_LAST;

    if (digit[2:1] == 2'd0) begin
      pair = {2'd0, hour_d};
    end else if (digit[2:1] == 2'd1) begin
      pair = minute_d;
    end else begin
      pair = second_d;
    end

    out_item_d.digit_index   = digit;
    out_item_d.digit_value   = digit[0] ? units_of(pair) : tens_of(pair);
    // Digit pair k belongs to setting field k+1; others blank while setting.
    out_item_d.digit_enable  = (field_d == FIELD_RUN) ||
                               ((digit[2:1] + 2'd1) == field_d);
    out_item_d.setting_field = field_d;
    out_item_d.hours_now     = hour_d;
    out_item_d.minutes_now   = minute_d;
    out_item_d.seconds_now   = second_d;
  end

  // --------------------------------------------------------------------------
  // State and result registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= HOUR_MIN;
      minute_q <= '0;
      second_q <= '0;
      scan_q   <= '0;
      repeat_q <= '0;
      field_q  <= FIELD_RUN;
    end else if (in_accept) begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      scan_q   <= scan_d;
      repeat_q <= repeat_d;
      field_q  <= field_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_accept_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o
  ) else $error("accepted item produced no result");

  a_time_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.hours_now >= HOUR_MIN &&
                     out_item_o.hours_now <= HOUR_MAX &&
                     out_item_o.minutes_now <= MS_MAX &&
                     out_item_o.seconds_now <= MS_MAX)
  ) else $error("reported time out of range");

  a_run_mode_shows_all: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.setting_field == FIELD_RUN) |->
      out_item_o.digit_enable
  ) else $error("digit blanked in run mode");

  a_run_mode_no_repeat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (field_q == FIELD_RUN) |-> (repeat_q == 8'd0)
  ) else $error("repeat count kept in run mode");

  a_threshold_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && paddr == ADDR_THRESHOLD) |=> threshold_q == $past(pwdata[7:0])
  ) else $error("threshold write lost");

endmodule

`default_nettype wire

// ===== tb/sv/twelve_hour_clock_with_setting_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for twelve_hour_clock_with_setting
// Drives second ticks, scan ticks and mode presses with held buttons through
// the valid/stall event channel and checks every display item against a
// cycle-free model of the clock. The repeat threshold is swept over its
// extremes through the APB port, and each write is read back.
// ----------------------------------------------------------------------------
module twelve_hour_clock_with_setting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thc_pkg::*;

  // Opcode 3 has no meaning in the block, but it still takes part in
  // button adjustment, so it is part of the stimulus.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned SATURATE_SCANS  = 1792;

  // Model of the clock. Events are folded in at the edge where the block
  // accepts them, and each one leaves the display item it must produce.
  class clock_display_tracker;
    logic [7:0] threshold;
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] scan_pos;
    logic [7:0] repeat_rounds;
    logic [1:0] field;
    out_item_t  expected_displays[$];
    int         errors;

    function new();
      threshold     = THRESHOLD_RESET;
      hours         = HOUR_MIN;
      minutes       = 6'd0;
      seconds       = 6'd0;
      scan_pos      = 3'd0;
      repeat_rounds = 8'd0;
      field         = FIELD_RUN;
      errors        = 0;
    endfunction

    function logic [3:0] hour_step(logic [3:0] h, bit up);
      if (up) begin
        return (h >= HOUR_MAX) ? HOUR_MIN : h + 4'd1;
      end
      return (h <= HOUR_MIN) ? HOUR_MAX : h - 4'd1;
    endfunction

    function logic [5:0] sixty_step(logic [5:0] v, bit up);
      if (up) begin
        return (v >= MS_MAX) ? 6'd0 : v + 6'd1;
      end
      return (v == 6'd0) ? MS_MAX : v - 6'd1;
    endfunction

    function void nudge_field(bit up);
      case (field)
        FIELD_HOURS:   hours   = hour_step(hours, up);
        FIELD_MINUTES: minutes = sixty_step(minutes, up);
        FIELD_SECONDS: seconds = sixty_step(seconds, up);
        default: ;
      endcase
    endfunction

    function void take_event(in_item_t ev);
      logic [2:0] digit;
      logic [5:0] pair;
      out_item_t  shown;
      case (ev.opcode)
        OP_SECOND: begin
          if (field == FIELD_RUN) begin
            seconds = sixty_step(seconds, 1'b1);
            if (seconds == 6'd0) begin
              minutes = sixty_step(minutes, 1'b1);
              if (minutes == 6'd0) begin
                hours = hour_step(hours, 1'b1);
              end
            end
          end
        end
        OP_SCAN: begin
          if (scan_pos >= SCAN_LAST) begin
            scan_pos = 3'd0;
            if (repeat_rounds != REPEAT_MAX) begin
              repeat_rounds++;
            end
          end else begin
            scan_pos++;
          end
        end
        OP_MODE: field = field + 2'd1;
        default: ;
      endcase

      // Adjustment sees the field selected by this very event.
      if (field != FIELD_RUN) begin
        if (repeat_rounds >= threshold) begin
          if (ev.inc_held) begin
            nudge_field(1'b1);
            repeat_rounds = 8'd0;
          end else if (ev.dec_held) begin
            nudge_field(1'b0);
            repeat_rounds = 8'd0;
          end
        end
      end else begin
        repeat_rounds = 8'd0;
      end

      digit = (scan_pos >= 3'd1 && scan_pos <= 3'd5) ? scan_pos - 3'd1 : DIGIT_LAST;
      pair  = (digit < 3'd2) ? {2'd0, hours} : ((digit < 3'd4) ? minutes : seconds);
      shown.digit_index   = digit;
      shown.digit_value   = 4'((digit[0] == 1'b0) ? pair / 6'd10 : pair % 6'd10);
      shown.digit_enable  = (field == FIELD_RUN) || ((digit[2:1] + 2'd1) == field);
      shown.setting_field = field;
      shown.hours_now     = hours;
      shown.minutes_now   = minutes;
      shown.seconds_now   = seconds;
      expected_displays.push_back(shown);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_display(out_item_t got);
      out_item_t want;
      if (expected_displays.size() == 0) begin
        $display("%0t: display item %h arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = expected_displays.pop_front();
      compare_field("digit_index", 8'(want.digit_index), 8'(got.digit_index));
      compare_field("digit_value", 8'(want.digit_value), 8'(got.digit_value));
      compare_field("digit_enable", 8'(want.digit_enable), 8'(got.digit_enable));
      compare_field("setting_field", 8'(want.setting_field), 8'(got.setting_field));
      compare_field("hours_now", 8'(want.hours_now), 8'(got.hours_now));
      compare_field("minutes_now", 8'(want.minutes_now), 8'(got.minutes_now));
      compare_field("seconds_now", 8'(want.seconds_now), 8'(got.seconds_now));
    endfunction
  endclass

  // Every input of the block starts at a known value; reset is asserted
  // from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [ADDR_W-1:0]     paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_item_t             out_item_o;
  logic [31:0]           prdata;
  logic                  pready;

  clock_display_tracker  tracker = new();

  // Idling controls: the chance in a hundred that the sender skips a cycle
  // and that the receiver stalls one, plus a request for a long hold-off.
  int unsigned           gap_pct       = 0;
  int unsigned           stall_pct     = 0;
  bit                    hold_off_req  = 1'b0;
  int unsigned           quiet_cycles  = 0;

  twelve_hour_clock_with_setting u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Both channels are observed at the rising edge, where the values seen
  // are the ones from before the edge. An accepted event is folded into
  // the model first, so a result taken at the same edge always finds its
  // expectation already queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (in_valid_i && !in_stall_o) begin
        tracker.take_event(in_item_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_display(out_item_o);
      end
    end
  end

  // Watchdog: a long run of cycles with no item moving on either channel
  // means the block has hung.
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk_i);
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: stalls at random at the current rate. When a hold-off is
  // requested it keeps the output stalled for a long stretch, counted here,
  // so that the output register fills and the input side backs up.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (int unsigned n = 1; n < HOLD_OFF_CYCLES; n++) begin
          @(negedge clk_i);
        end
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t make_event(logic [1:0] op, bit inc, bit dec);
    in_item_t ev;
    ev.opcode   = op;
    ev.inc_held = inc;
    ev.dec_held = dec;
    return ev;
  endfunction

  // Random event, weighted toward scan ticks so that the repeat counter
  // climbs, with enough mode presses to visit every setting field.
  function automatic in_item_t random_event();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 55) begin
      op = OP_SCAN;
    end else if (pick < 80) begin
      op = OP_SECOND;
    end else if (pick < 90) begin
      op = OP_MODE;
    end else begin
      op = OP_UNUSED;
    end
    return make_event(op, $urandom_range(99) < 40, $urandom_range(99) < 40);
  endfunction

  // Offers one event, with random idle cycles ahead of it, and holds it
  // unchanged until the block takes it. Returns just after the accepting
  // edge.
  task automatic send_event(in_item_t ev);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      in_item_i  <= 4'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) begin
      send_event(random_event());
    end
  endtask

  // Stops offering events and waits for every expected display item, then
  // lets the block settle. Each event gives exactly one result.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.expected_displays.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_read_check(logic [7:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_THRESHOLD;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    if (prdata !== {24'd0, want}) begin
      $display("%0t: repeat_threshold read expected %0d, got %0d", $time, want, prdata);
      tracker.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The threshold is only changed once the block has gone quiet; the model
  // takes the new value at the edge where the write lands.
  task automatic set_threshold(logic [7:0] value);
    drain_pipeline();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_THRESHOLD;
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    tracker.threshold = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apb_read_check(value);
  endtask

  initial begin
    logic [1:0]  presses;
    int unsigned scans;
    in_item_t    ev;

    repeat (6) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The threshold must come out of reset at six.
    apb_read_check(THRESHOLD_RESET);

    // Directed part with a zero threshold, so that every event with a held
    // button adjusts while setting. Decrementing from reset wraps hours 1 to
    // 12 and minutes and seconds 0 to 59; the press out of seconds setting
    // ignores its held button.
    set_threshold(8'd0);
    send_event(make_event(OP_MODE, 1'b0, 1'b1));
    send_event(make_event(OP_MODE, 1'b0, 1'b1));
    send_event(make_event(OP_MODE, 1'b0, 1'b1));
    send_event(make_event(OP_MODE, 1'b1, 1'b0));
    // 12:59:59 plus one second carries all the way and wraps to 1:00:00.
    send_event(make_event(OP_SECOND, 1'b0, 1'b0));
    // The unused opcode changes nothing in run mode, buttons or not.
    send_event(make_event(OP_UNUSED, 1'b1, 1'b1));
    // A full scan round shows every digit and wraps back to position zero.
    repeat (7) begin
      send_event(make_event(OP_SCAN, 1'b0, 1'b0));
    end
    // Into hours setting with both buttons held: increment wins.
    send_event(make_event(OP_MODE, 1'b1, 1'b1));
    // Second ticks are ignored while setting, but the button still acts.
    send_event(make_event(OP_SECOND, 1'b1, 1'b0));
    send_event(make_event(OP_UNUSED, 1'b1, 1'b0));
    send_event(make_event(OP_SCAN, 1'b0, 1'b1));
    send_event(make_event(OP_MODE, 1'b1, 1'b0));
    send_event(make_event(OP_MODE, 1'b0, 1'b0));
    send_event(make_event(OP_SECOND, 1'b0, 1'b1));
    send_event(make_event(OP_MODE, 1'b0, 1'b0));

    // Random traffic with no idling at all.
    run_random(30);

    // Smallest nonzero threshold, sender mostly idle.
    set_threshold(8'd1);
    gap_pct   = 80;
    stall_pct = 0;
    run_random(20);

    // Receiver mostly stalled, and first a long hold-off while the sender
    // keeps offering, so the block backs up into its input.
    set_threshold(8'd2);
    gap_pct      = 0;
    stall_pct    = 80;
    hold_off_req = 1'b1;
    run_random(20);

    // Reset value again, with light idling on both sides.
    set_threshold(THRESHOLD_RESET);
    gap_pct   = 11;
    stall_pct = 11;
    run_random(25);

    // Largest threshold. Sitting in minutes setting with no button held,
    // the repeat counter climbs past 255 scan rounds and must saturate, so
    // the held buttons afterwards still adjust.
    set_threshold(REPEAT_MAX);
    presses = FIELD_MINUTES - tracker.field;
    repeat (presses) begin
      send_event(make_event(OP_MODE, 1'b0, 1'b0));
    end
    scans = 0;
    while (scans < SATURATE_SCANS) begin
      ev = random_event();
      if (ev.opcode == OP_MODE) begin
        ev.opcode = OP_SCAN;
      end
      if ($urandom_range(99) < 95) begin
        ev.opcode = OP_SCAN;
      end
      ev.inc_held = 1'b0;
      ev.dec_held = 1'b0;
      if (ev.opcode == OP_SCAN) begin
        scans++;
      end
      send_event(ev);
    end
    repeat (16) begin
      send_event(make_event(OP_SCAN, 1'($urandom_range(1)), 1'($urandom_range(1))));
    end
    run_random(10);

    // A middle threshold to finish, back at full speed.
    set_threshold(8'd3);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(10);

    drain_pipeline();
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
